// File: design/assert_macros.svh
// Assertion macros used by the checker file of the priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/spq_pkg.sv
// Package of shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DATA_W = 32;
	localparam int OCC_W = 5;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	typedef struct packed {
		logic                     enq;
		logic                     deq;
		logic signed [DATA_W-1:0] data;
		logic signed [DATA_W-1:0] prio;
	} spq_cmd_t;

endpackage

// File: design/spq_cell.sv
// One storage cell of the sorted chain, holding a single data and priority pair.
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
	input  logic                     clk,
	input  spq_cmd_t                 cmd,
	input  logic                     occupied,
	input  logic                     left_ge,
	input  logic signed [DATA_W-1:0] left_data,
	input  logic signed [DATA_W-1:0] left_prio,
	input  logic signed [DATA_W-1:0] right_data,
	input  logic signed [DATA_W-1:0] right_prio,
	output logic                     own_ge,
	output logic signed [DATA_W-1:0] data,
	output logic signed [DATA_W-1:0] prio
);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] prio_q;

	assign own_ge = occupied && ($signed(prio_q) >= $signed(cmd.prio));
	assign data = data_q;
	assign prio = prio_q;

	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			if (!own_ge) begin
				if (left_ge) begin
					data_q <= cmd.data;
					prio_q <= cmd.prio;
				end else begin
					data_q <= left_data;
					prio_q <= left_prio;
				end
			end
		end else if (cmd.deq) begin
			data_q <= right_data;
			prio_q <= right_prio;
		end
	end

endmodule

// File: design/sorted_priority_queue.sv
// A result word appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while no result word is stalled; every cell compares and shifts in the same cycle.
// A stalled result holds in the output register and blocks further input words.
// Reset clears the entry count and the output valid flag; the cells hold no reset.
// The queue is usable as soon as reset is released.
`timescale 1ns / 1ps

module sorted_priority_queue import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     command,
	input  logic signed [DATA_W-1:0] item_data,
	input  logic signed [DATA_W-1:0] item_priority,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] out_data,
	output logic signed [DATA_W-1:0] out_priority,
	output logic [OCC_W-1:0]         occupancy
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_next;
	logic                     out_valid_q;
	spq_status_t              status_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic signed [DATA_W-1:0] out_prio_q;
	logic [OCC_W-1:0]         occ_q;

	logic     fire;
	logic     full;
	logic     empty;
	spq_cmd_t cmd;
	spq_status_t status_next;

	logic                     ge_w   [QUEUE_DEPTH];
	logic signed [DATA_W-1:0] data_w [QUEUE_DEPTH];
	logic signed [DATA_W-1:0] prio_w [QUEUE_DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign fire = in_valid && in_ready;
	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	assign cmd.enq = fire && (command == CMD_ENQ) && !full;
	assign cmd.deq = fire && (command == CMD_DEQ) && !empty;
	assign cmd.data = item_data;
	assign cmd.prio = item_priority;

	always_comb begin
		count_next = count_q;
		status_next = ST_DONE;
		if (cmd.enq) begin
			count_next = count_q + CW'(1);
		end else if (cmd.deq) begin
			count_next = count_q - CW'(1);
		end
		if ((command == CMD_DEQ) && empty) begin
			status_next = ST_EMPTY;
		end else if ((command == CMD_ENQ) && full) begin
			status_next = ST_FULL;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic                     occupied;
		logic                     left_ge;
		logic signed [DATA_W-1:0] left_data;
		logic signed [DATA_W-1:0] left_prio;
		logic signed [DATA_W-1:0] right_data;
		logic signed [DATA_W-1:0] right_prio;

		assign occupied = (IDX < count_q);

		if (i == 0) begin : g_head
			assign left_ge = 1'b1;
			assign left_data = item_data;
			assign left_prio = item_priority;
		end else begin : g_body
			assign left_ge = ge_w[i-1];
			assign left_data = data_w[i-1];
			assign left_prio = prio_w[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_data = data_w[i];
			assign right_prio = prio_w[i];
		end else begin : g_inner
			assign right_data = data_w[i+1];
			assign right_prio = prio_w[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (occupied),
			.left_ge    (left_ge),
			.left_data  (left_data),
			.left_prio  (left_prio),
			.right_data (right_data),
			.right_prio (right_prio),
			.own_ge     (ge_w[i]),
			.data       (data_w[i]),
			.prio       (prio_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_next;
			out_data_q <= cmd.deq ? data_w[0] : '0;
			out_prio_q <= cmd.deq ? prio_w[0] : '0;
			occ_q <= OCC_W'(count_next);
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_data = out_data_q;
	assign out_priority = out_prio_q;
	assign occupancy = occ_q;

endmodule

// File: design/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spq_checker import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [1:0]               status,
	input logic signed [DATA_W-1:0] out_data,
	input logic signed [DATA_W-1:0] out_priority,
	input logic [OCC_W-1:0]         occupancy
);

	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

	`SPQ_ASSERT_NOW(a_full_occ, out_valid && (status == ST_FULL), occupancy == OCC_FULL, "Full status with a queue that is not full")
	`SPQ_ASSERT_NOW(a_empty_word, out_valid && (status == ST_EMPTY), (occupancy == '0) && (out_data == '0) && (out_priority == '0), "Empty status with nonzero fields")
	`SPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(out_data) && $stable(occupancy), "Stalled result word changed")
	`SPQ_ASSERT_NOW(a_ready_stall, out_valid && !out_ready, !in_ready, "Input taken while a result word is stalled")
	`SPQ_ASSERT_NEXT(a_in_to_out, in_valid && in_ready, out_valid, "Accepted input word gave no result word")

endmodule

bind sorted_priority_queue spq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.out_data     (out_data),
	.out_priority (out_priority),
	.occupancy    (occupancy)
);
